### design/sbpf_pkg.sv
package sbpf_pkg;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_PARAM  = 1'b1;

    localparam logic [7:0] PREAMBLE  = 8'hFF;
    localparam logic [7:0] LEN_EXTRA = 8'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [2:0] IDX_SYNC_A = 3'd0;
    localparam logic [2:0] IDX_SYNC_B = 3'd1;
    localparam logic [2:0] IDX_ID     = 3'd2;
    localparam logic [2:0] IDX_LEN    = 3'd3;
    localparam logic [2:0] IDX_INST   = 3'd4;
    localparam logic [2:0] IDX_HDR_CHK = 3'd5;
    localparam logic [2:0] IDX_BYTE   = 3'd0;
    localparam logic [2:0] IDX_PAR_CHK = 3'd1;

    typedef enum logic [1:0] {
        CMD_ERROR,
        CMD_HEADER,
        CMD_PARAM
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] byte_a;
        logic [7:0] len;
        logic [7:0] inst;
        logic [7:0] chk;
        logic       with_chk;
    } cmd_t;

endpackage

### design/servo_bus_packet_framer_top.sv
// servo-bus instruction packet framer, protocol 1.0
// input channel: in_valid / in_stall carry one word per accepted item;
// operation 0 is a header (servo_id, instruction, param_count), 1 is one
// parameter byte. output channel: out_valid / out_stall carry one wire byte
// per word with packet_end on the checksum, run_last on the last byte of
// the input word, and seq_error on a single zero byte for an out-of-order word.
// a header gives five bytes (six with the checksum when param_count is zero),
// a parameter gives one byte (two on the last parameter).
// an accepted input word is written into the command queue, then its first byte into the output register.
// throughput: one output byte per cycle while out_stall is low, set by the single output register;
// parameter words flow at one per cycle while out_stall is low, a header holds the back end
// for all of its bytes and the two-entry command queue then raises in_stall.
// when out_stall is high the output word holds and the queue fills, after
// which in_stall rises; nothing is dropped.
// reset clears the open-packet state, running checksum, queue and output valid flag.
module servo_bus_packet_framer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [7:0] servo_id,
    input  logic [7:0] instruction,
    input  logic [7:0] param_count,
    input  logic [7:0] param_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       packet_end,
    output logic       run_last,
    output logic       seq_error
);
    import sbpf_pkg::*;

    cmd_t cmd;
    cmd_t head;
    logic full;
    logic empty;
    logic pop;
    logic accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    sbpf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .operation   (operation),
        .servo_id    (servo_id),
        .instruction (instruction),
        .param_count (param_count),
        .param_byte  (param_byte),
        .cmd         (cmd)
    );

    sbpf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (cmd),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head)
    );

    sbpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .packet_end (packet_end),
        .run_last   (run_last),
        .seq_error  (seq_error)
    );

endmodule

### design/sbpf_front.sv
module sbpf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          operation,
    input  logic [7:0]    servo_id,
    input  logic [7:0]    instruction,
    input  logic [7:0]    param_count,
    input  logic [7:0]    param_byte,
    output sbpf_pkg::cmd_t cmd
);
    import sbpf_pkg::*;

    logic [7:0] sum_reg, sum_next;
    logic [7:0] left_reg, left_next;
    logic       open_reg, open_next;
    logic [7:0] len;
    logic [7:0] hsum;
    logic [7:0] psum;

    assign len  = param_count + LEN_EXTRA;
    assign hsum = servo_id + len + instruction;
    assign psum = sum_reg + param_byte;

    always_comb
    begin
        cmd       = '0;
        cmd.kind  = CMD_ERROR;
        sum_next  = sum_reg;
        left_next = left_reg;
        open_next = open_reg;
        unique case (operation)
            OP_HEADER:
            begin
                if (!open_reg)
                begin
                    cmd.kind     = CMD_HEADER;
                    cmd.byte_a   = servo_id;
                    cmd.len      = len;
                    cmd.inst     = instruction;
                    cmd.chk      = ~hsum;
                    cmd.with_chk = (param_count == 8'd0);
                    if (param_count != 8'd0)
                    begin
                        open_next = 1'b1;
                        sum_next  = hsum;
                        left_next = param_count;
                    end
                end
            end
            OP_PARAM:
            begin
                if (open_reg)
                begin
                    cmd.kind     = CMD_PARAM;
                    cmd.byte_a   = param_byte;
                    cmd.chk      = ~psum;
                    cmd.with_chk = (left_reg == 8'd1);
                    left_next    = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        open_next = 1'b0;
                        sum_next  = 8'd0;
                    end
                    else
                    begin
                        sum_next = psum;
                    end
                end
            end
            default:
            begin
                cmd.kind = CMD_ERROR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= 8'd0;
            left_reg <= 8'd0;
            open_reg <= 1'b0;
        end
        else if (accept)
        begin
            sum_reg  <= sum_next;
            left_reg <= left_next;
            open_reg <= open_next;
        end
    end

endmodule

### design/sbpf_queue.sv
module sbpf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sbpf_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output sbpf_pkg::cmd_t head
);
    import sbpf_pkg::*;

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### design/sbpf_back.sv
module sbpf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  sbpf_pkg::cmd_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     out_byte,
    output logic           packet_end,
    output logic           run_last,
    output logic           seq_error
);
    import sbpf_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg, byte_next;
    logic       end_reg, end_next;
    logic       last_reg, last_next;
    logic       err_reg, err_next;
    logic [2:0] idx_reg, idx_next;
    logic       load;

    assign load = !valid_reg || !out_stall;

    always_comb
    begin
        byte_next = 8'd0;
        end_next  = 1'b0;
        last_next = 1'b0;
        err_next  = 1'b0;
        unique case (head.kind)
            CMD_HEADER:
            begin
                unique case (idx_reg)
                    IDX_SYNC_A, IDX_SYNC_B: byte_next = PREAMBLE;
                    IDX_ID:                 byte_next = head.byte_a;
                    IDX_LEN:                byte_next = head.len;
                    IDX_INST:               byte_next = head.inst;
                    default:
                    begin
                        byte_next = head.chk;
                        end_next  = 1'b1;
                    end
                endcase
                last_next = head.with_chk ? (idx_reg == IDX_HDR_CHK)
                                          : (idx_reg == IDX_INST);
            end
            CMD_PARAM:
            begin
                if (idx_reg == IDX_BYTE)
                begin
                    byte_next = head.byte_a;
                end
                else
                begin
                    byte_next = head.chk;
                    end_next  = 1'b1;
                end
                last_next = head.with_chk ? (idx_reg == IDX_PAR_CHK)
                                          : (idx_reg == IDX_BYTE);
            end
            default:
            begin
                err_next  = 1'b1;
                last_next = 1'b1;
            end
        endcase
        pop      = load && !empty && last_next;
        idx_next = idx_reg;
        if (load && !empty)
        begin
            idx_next = last_next ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                valid_reg <= !empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            byte_reg <= byte_next;
            end_reg  <= end_next;
            last_reg <= last_next;
            err_reg  <= err_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign packet_end = end_reg;
    assign run_last   = last_reg;
    assign seq_error  = err_reg;

endmodule

### tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sbpf_pkg::*;

    typedef struct {
        logic [7:0] wire_byte;
        logic       is_end;
        logic       is_last;
        logic       is_err;
    } wire_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       operation = OP_HEADER;
    logic [7:0] servo_id = 8'h00;
    logic [7:0] instruction = 8'h00;
    logic [7:0] param_count = 8'h00;
    logic [7:0] param_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       packet_end;
    logic       run_last;
    logic       seq_error;

    wire_word_t wire_bytes_due[$];
    logic [7:0] chk_sum = 8'h00;
    logic [7:0] params_left = 8'h00;
    logic       pkt_open = 1'b0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         failures = 0;

    servo_bus_packet_framer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .servo_id    (servo_id),
        .instruction (instruction),
        .param_count (param_count),
        .param_byte  (param_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .packet_end  (packet_end),
        .run_last    (run_last),
        .seq_error   (seq_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_stall = ($urandom_range(99) < recv_stall_pct);
        else
            out_stall = 1'b0;
    end

    function automatic void push_wire_byte(logic [7:0] b, logic e, logic l, logic err);
        wire_word_t w;
        w.wire_byte = b;
        w.is_end    = e;
        w.is_last   = l;
        w.is_err    = err;
        wire_bytes_due = {wire_bytes_due, w};
    endfunction

    function automatic void predict_wire_bytes(logic op, logic [7:0] id, logic [7:0] inst,
                                               logic [7:0] cnt, logic [7:0] pb);
        logic [7:0] len;
        logic [7:0] hdr_sum;
        if (op == OP_HEADER)
        begin
            if (pkt_open)
            begin
                push_wire_byte(8'h00, 1'b0, 1'b1, 1'b1);
                return;
            end
            len = cnt + LEN_EXTRA;
            hdr_sum = id + len + inst;
            push_wire_byte(PREAMBLE, 1'b0, 1'b0, 1'b0);
            push_wire_byte(PREAMBLE, 1'b0, 1'b0, 1'b0);
            push_wire_byte(id, 1'b0, 1'b0, 1'b0);
            push_wire_byte(len, 1'b0, 1'b0, 1'b0);
            if (cnt == 8'd0)
            begin
                push_wire_byte(inst, 1'b0, 1'b0, 1'b0);
                push_wire_byte(~hdr_sum, 1'b1, 1'b1, 1'b0);
                chk_sum = 8'h00;
                params_left = 8'h00;
                pkt_open = 1'b0;
            end
            else
            begin
                push_wire_byte(inst, 1'b0, 1'b1, 1'b0);
                chk_sum = hdr_sum;
                params_left = cnt;
                pkt_open = 1'b1;
            end
        end
        else
        begin
            if (!pkt_open)
            begin
                push_wire_byte(8'h00, 1'b0, 1'b1, 1'b1);
                return;
            end
            chk_sum = chk_sum + pb;
            params_left = params_left - 8'd1;
            if (params_left == 8'd0)
            begin
                push_wire_byte(pb, 1'b0, 1'b0, 1'b0);
                push_wire_byte(~chk_sum, 1'b1, 1'b1, 1'b0);
                chk_sum = 8'h00;
                pkt_open = 1'b0;
            end
            else
                push_wire_byte(pb, 1'b0, 1'b1, 1'b0);
        end
    endfunction

    // compare each wire byte with the oldest prediction
    always @(posedge clk)
    begin
        wire_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (wire_bytes_due.size() == 0)
            begin
                $error("unexpected word: out_byte %h packet_end %b run_last %b seq_error %b",
                       out_byte, packet_end, run_last, seq_error);
                failures++;
            end
            else
            begin
                want = wire_bytes_due.pop_front();
                if (out_byte !== want.wire_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.wire_byte, out_byte);
                    failures++;
                end
                if (packet_end !== want.is_end)
                begin
                    $error("packet_end: expected %b, got %b", want.is_end, packet_end);
                    failures++;
                end
                if (run_last !== want.is_last)
                begin
                    $error("run_last: expected %b, got %b", want.is_last, run_last);
                    failures++;
                end
                if (seq_error !== want.is_err)
                begin
                    $error("seq_error: expected %b, got %b", want.is_err, seq_error);
                    failures++;
                end
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_word(logic op, logic [7:0] id, logic [7:0] inst,
                             logic [7:0] cnt, logic [7:0] pb);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid    = 1'b0;
            operation   = 1'($urandom_range(1));
            servo_id    = 8'($urandom_range(255));
            instruction = 8'($urandom_range(255));
            param_count = 8'($urandom_range(255));
            param_byte  = 8'($urandom_range(255));
            @(negedge clk);
        end
        in_valid    = 1'b1;
        operation   = op;
        servo_id    = id;
        instruction = inst;
        param_count = cnt;
        param_byte  = pb;
        do
        begin
            @(posedge clk);
            taken = !in_stall;
            if (taken)
                predict_wire_bytes(op, id, inst, cnt, pb);
            @(negedge clk);
        end
        while (!taken);
        in_valid = 1'b0;
    endtask

    // unused fields carry random values
    task automatic send_header(logic [7:0] id, logic [7:0] inst, logic [7:0] cnt);
        send_word(OP_HEADER, id, inst, cnt, 8'($urandom_range(255)));
    endtask

    task automatic send_param(logic [7:0] pb);
        send_word(OP_PARAM, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), pb);
    endtask

    task automatic wait_drained();
        while (wire_bytes_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_header_only();
        send_header(8'h00, 8'h00, 8'd0);
        send_header(8'hFF, 8'hFF, 8'd0);
        send_header(8'hFE, 8'h01, 8'd0);
    endtask

    task automatic test_param_bytes();
        send_header(8'h01, 8'h03, 8'd1);
        send_param(8'hFF);
        send_header(8'hFE, 8'h83, 8'd3);
        send_param(8'h00);
        send_param(8'hFF);
        send_param(8'h80);
    endtask

    task automatic test_sequence_errors();
        send_param(8'hFF);
        send_header(8'h02, 8'h02, 8'd2);
        send_header(8'hFF, 8'hFF, 8'hFF);
        send_param(8'h55);
        send_header(8'h00, 8'h00, 8'd0);
        send_param(8'hAA);
    endtask

    // largest count, the length byte wraps to one
    task automatic test_length_wrap();
        int k;
        send_header(8'hFE, 8'($urandom_range(255)), 8'hFF);
        for (k = 0; k < 255; k++)
            send_param(8'($urandom_range(255)));
    endtask

    task automatic test_random_packets(int n_items);
        int sent;
        int cnt;
        int k;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_param(8'($urandom_range(255)));
                sent++;
            end
            else
            begin
                if ($urandom_range(9) == 0)
                    cnt = $urandom_range(24, 7);
                else
                    cnt = $urandom_range(4);
                send_header(8'($urandom_range(255)), 8'($urandom_range(255)), cnt[7:0]);
                sent++;
                for (k = 0; k < cnt; k++)
                begin
                    if ($urandom_range(29) == 0)
                    begin
                        send_header(8'($urandom_range(255)), 8'($urandom_range(255)),
                                    8'($urandom_range(255)));
                        sent++;
                    end
                    send_param(8'($urandom_range(255)));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(21, 87);
        test_header_only();
        test_param_bytes();
        test_sequence_errors();
        wait_drained();
        test_random_packets(6);

        set_idling(87, 21);
        test_random_packets(8);
        wait_drained();

        set_idling(0, 0);
        test_length_wrap();

        wait_drained();
        repeat (10) @(negedge clk);
        if (failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
